// ===== hw/rtl/rau_pkg.sv =====
package rau_pkg;

  localparam int WIDTH = 32;
  localparam int DW = 2 * WIDTH;
  localparam int CW = $clog2(DW + 1);

  localparam logic [2:0] OP_NORM = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]       opcode;
    logic             a_neg;
    logic [WIDTH-1:0] a_mag;
    logic [WIDTH-1:0] a_den;
    logic             b_neg;
    logic [WIDTH-1:0] b_mag;
    logic [WIDTH-1:0] b_den;
  } job_t;

  function automatic logic [WIDTH:0] split(input logic [31:0] v);
    logic [WIDTH-1:0] m;
    m = v[WIDTH-1:0];
    if (m[WIDTH-1]) begin
      split = {1'b1, WIDTH'(~m + 1'b1)};
    end else begin
      split = {1'b0, m};
    end
  endfunction

endpackage

// ===== hw/rtl/rau_front.sv =====
module rau_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [127:0]   s_tdata,
  input  logic [2:0]     s_tuser,
  output logic           q_valid,
  input  logic           q_ready,
  output rau_pkg::job_t  q_job
);

  localparam int W = rau_pkg::WIDTH;

  rau_pkg::job_t slot [2];
  logic [1:0] full;
  logic wr_ptr, rd_ptr;
  rau_pkg::job_t job_in;
  logic [W:0] an, ad, bn, bd;
  logic [2:0] op;

  always_comb begin
    an = rau_pkg::split(s_tdata[31:0]);
    ad = rau_pkg::split(s_tdata[63:32]);
    bn = rau_pkg::split(s_tdata[95:64]);
    bd = rau_pkg::split(s_tdata[127:96]);
    op = (s_tuser > rau_pkg::OP_DIV) ? rau_pkg::OP_NORM : s_tuser;
    job_in.opcode = op;
    job_in.a_mag  = an[W-1:0];
    job_in.a_den  = ad[W-1:0];
    job_in.a_neg  = (an[W] != ad[W]) && (an[W-1:0] != '0);
    job_in.b_mag  = bn[W-1:0];
    job_in.b_den  = bd[W-1:0];
    job_in.b_neg  = (bn[W] != bd[W]) && (bn[W-1:0] != '0);
  end

  assign s_tready = !full[wr_ptr];
  assign q_valid  = full[rd_ptr];
  assign q_job    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      slot[wr_ptr] <= job_in;
    end
    if (rst) begin
      full   <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        full[wr_ptr] <= 1'b1;
        wr_ptr       <= !wr_ptr;
      end
      if (q_valid && q_ready) begin
        full[rd_ptr] <= 1'b0;
        rd_ptr       <= !rd_ptr;
      end
    end
  end

endmodule

// ===== hw/rtl/rau_back.sv =====
module rau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  rau_pkg::job_t  q_job,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [63:0]    m_tdata,
  output logic [3:0]     m_tuser
);

  localparam int W  = rau_pkg::WIDTH;
  localparam int DW = rau_pkg::DW;
  localparam int CW = rau_pkg::CW;
  localparam int IW = $clog2(DW);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL1 = 7'b0000010,
    S_MUL2 = 7'b0000100,
    S_COMB = 7'b0001000,
    S_GCD  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  rau_pkg::job_t job;
  logic [DW-1:0] p1, p2, p3, p4;
  logic [DW-1:0] rmag, rden, ga, gb, quo, rem;
  logic [DW:0]   rem_try;
  logic [CW-1:0] cnt;
  logic [IW-1:0] bsel;
  logic dbit;
  logic rneg, div_den, less, equal, zero, n2;
  logic zero_r, gcd_init;
  logic [W-1:0] mx1, mx2, my1, my2;
  logic [DW-1:0] dividend, divisor;

  always_comb begin
    mx1 = job.a_mag; my1 = job.b_den;
    mx2 = job.b_mag; my2 = job.a_den;
    if (state == S_MUL2) begin
      mx1 = job.a_mag; my1 = job.b_mag;
      mx2 = job.a_den; my2 = job.b_den;
    end
  end

  always_comb begin
    zero = (job.a_den == '0) || (job.opcode != rau_pkg::OP_NORM && job.b_den == '0)
           || (job.opcode == rau_pkg::OP_DIV && job.b_mag == '0);
    n2   = ((job.opcode == rau_pkg::OP_SUB) ? !job.b_neg : job.b_neg)
           && (job.b_mag != '0);
  end

  // shared restoring divider: gcd remainders and the two final quotients
  always_comb begin
    dividend = ga;
    divisor  = gb;
    if (state == S_DIV) begin
      dividend = div_den ? rden : rmag;
      divisor  = ga;
    end
    bsel    = IW'(cnt - 1'b1);
    dbit    = dividend[bsel];
    rem_try = {rem, dbit} - {1'b0, divisor};
  end

  assign q_ready = (state == S_IDLE);
  assign m_tvalid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job   <= q_job;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1 <= DW'(mx1) * DW'(my1);
          p2 <= DW'(mx2) * DW'(my2);
          state <= S_MUL2;
        end
        S_MUL2: begin
          p3 <= DW'(mx1) * DW'(my1);
          p4 <= DW'(mx2) * DW'(my2);
          state <= S_COMB;
        end
        S_COMB: begin
          less  <= 1'b0;
          equal <= 1'b0;
          if (job.a_den != '0 && job.b_den != '0) begin
            equal <= (job.a_neg == job.b_neg) && (p1 == p2);
            less  <= (job.a_neg && !job.b_neg) ? 1'b1 :
                     (!job.a_neg && job.b_neg) ? 1'b0 :
                     job.a_neg ? (p1 > p2) : (p1 < p2);
          end
          case (job.opcode)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
              rden <= p4;
              if (job.a_neg == n2) begin
                rmag <= p1 + p2; rneg <= job.a_neg;
              end else if (p1 >= p2) begin
                rmag <= p1 - p2; rneg <= job.a_neg;
              end else begin
                rmag <= p2 - p1; rneg <= n2;
              end
            end
            rau_pkg::OP_MUL: begin
              rmag <= p3; rden <= p4; rneg <= job.a_neg != job.b_neg;
            end
            rau_pkg::OP_DIV: begin
              rmag <= p1; rden <= p2;
              rneg <= job.a_neg != job.b_neg;
            end
            default: begin
              rmag <= DW'(job.a_mag); rden <= DW'(job.a_den); rneg <= job.a_neg;
            end
          endcase
          zero_r <= zero;
          if (zero) begin
            state <= S_DONE;
          end else begin
            state <= S_GCD;
            ga <= '0; gb <= '0;
            gcd_init <= 1'b1;
          end
        end
        S_GCD: begin
          if (gcd_init) begin
            gcd_init <= 1'b0;
            ga  <= rmag;
            gb  <= rden;
            rem <= '0;
            cnt <= CW'(DW);
          end else if (gb == '0) begin
            state   <= S_DIV;
            div_den <= 1'b0;
            rem     <= '0;
            quo     <= '0;
            cnt     <= CW'(DW);
          end else if (cnt != '0) begin
            rem <= rem_try[DW] ? {rem[DW-2:0], dbit} : rem_try[DW-1:0];
            cnt <= cnt - 1'b1;
          end else begin
            ga  <= gb;
            gb  <= rem;
            rem <= '0;
            cnt <= CW'(DW);
          end
        end
        S_DIV: begin
          if (cnt != '0) begin
            rem <= rem_try[DW] ? {rem[DW-2:0], dbit} : rem_try[DW-1:0];
            quo <= {quo[DW-2:0], !rem_try[DW]};
            cnt <= cnt - 1'b1;
          end else if (!div_den) begin
            rmag    <= quo;
            div_den <= 1'b1;
            rem     <= '0;
            quo     <= '0;
            cnt     <= CW'(DW);
          end else begin
            rden  <= quo;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [DW-1:0] lim, sv;
  logic numok;
  logic [1:0] status;
  logic [W-1:0] wv;
  logic [31:0] res_num;
  logic [30:0] res_den;

  always_comb begin
    lim   = DW'(1) << (W - 1);
    numok = (rneg && rmag != '0) ? (rmag <= lim) : (rmag < lim);
    sv    = (rneg && rmag != '0) ? (~rmag + 1'b1) : rmag;
    wv    = sv[W-1:0];
    res_num = 32'(signed'(wv));
    res_den = 31'(rden[W-2:0]);
    status  = rau_pkg::ST_OK;
    if (zero_r) begin
      status  = rau_pkg::ST_ZERO;
      res_num = '0;
      res_den = '0;
    end else if (!numok || rden >= lim) begin
      status = rau_pkg::ST_OVF;
    end
  end

  assign m_tdata = {1'b0, res_den, res_num};
  assign m_tuser = {status, equal, less};

endmodule

// ===== hw/rtl/rational_arithmetic_unit_core.sv =====
// Rational arithmetic on two signed fractions: one result per transfer.
// A front stage checks and splits each operand into sign and magnitude and
// holds up to two transfers; the back stage forms cross products with two
// 32x32 multipliers, reduces by the Euclidean gcd on a shared bit-serial
// divider and divides both terms by the gcd; a zero denominator or a zero
// divisor skips the gcd and the divider.
module rational_arithmetic_unit_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // a_num, a_den, b_num, b_den
  input  logic [2:0]   s_tuser,  // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // res_num, res_den, zero pad
  output logic [3:0]   m_tuser   // a_less, a_equal, status
);

  logic q_valid, q_ready;
  rau_pkg::job_t q_job;

  rau_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .q_valid, .q_ready, .q_job
  );

  rau_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_job,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

endmodule

// ===== hw/rtl/rau_checker.sv =====
module rau_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [3:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[3:2] != 2'd3)
    else $error("bad status");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3:2] == 2'd1 |-> m_tdata[62:0] == '0)
    else $error("zero case not cleared");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("less and equal together");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [3:0]   m_tuser;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        less;
    logic        equal;
    logic [1:0]  status;
  } quotient_t;

  quotient_t   expected_q[$];
  int          errors = 0;
  longint      cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;
  localparam longint CYCLE_LIMIT = 64'd40000000;

  rational_arithmetic_unit_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void split_val(input logic [31:0] v, output logic neg,
                                    output logic [63:0] mag);
    logic [rau_pkg::WIDTH-1:0] m;
    m = v[rau_pkg::WIDTH-1:0];
    neg = m[rau_pkg::WIDTH-1];
    mag = neg ? 64'(rau_pkg::WIDTH'(-m)) : 64'(m);
    if (neg && mag == 0) mag = 64'd1 << (rau_pkg::WIDTH - 1);
  endfunction

  function automatic longint signed_val(input logic neg, input logic [63:0] mag);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic quotient_t compute_fraction(input logic [2:0] op_in,
      input logic [31:0] an, ad, bn, bd);
    quotient_t r;
    logic [2:0] op;
    logic nn, dn, a_neg, b_neg, n1, n2, rneg;
    logic [63:0] a_mag, a_den, b_mag, b_den, t1, t2, rmag, rden, g, x, y, t, lim, v;
    op = (op_in > rau_pkg::OP_DIV) ? rau_pkg::OP_NORM : op_in;
    split_val(an, nn, a_mag); split_val(ad, dn, a_den);
    a_neg = (nn != dn) && a_mag != 0;
    split_val(bn, nn, b_mag); split_val(bd, dn, b_den);
    b_neg = (nn != dn) && b_mag != 0;
    r.less = 0; r.equal = 0; r.status = rau_pkg::ST_OK;
    rneg = 0; rmag = 0; rden = 1;
    if (a_den != 0 && b_den != 0) begin
      r.less = signed_val(a_neg, a_mag * b_den) < signed_val(b_neg, b_mag * a_den);
      r.equal = signed_val(a_neg, a_mag * b_den) == signed_val(b_neg, b_mag * a_den);
    end
    if (a_den == 0 || (op != rau_pkg::OP_NORM && b_den == 0) ||
        (op == rau_pkg::OP_DIV && b_mag == 0)) begin
      r.status = rau_pkg::ST_ZERO;
    end else begin
      case (op)
        rau_pkg::OP_NORM: begin
          rneg = a_neg; rmag = a_mag; rden = a_den;
        end
        rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
          n1 = a_neg;
          n2 = (op == rau_pkg::OP_SUB) ? !b_neg : b_neg;
          if (b_mag == 0) n2 = 0;
          t1 = a_mag * b_den; t2 = b_mag * a_den;
          if (n1 == n2) begin
            rmag = t1 + t2; rneg = n1;
          end else if (t1 >= t2) begin
            rmag = t1 - t2; rneg = n1;
          end else begin
            rmag = t2 - t1; rneg = n2;
          end
          rden = a_den * b_den;
        end
        rau_pkg::OP_MUL: begin
          rmag = a_mag * b_mag; rneg = a_neg != b_neg; rden = a_den * b_den;
        end
        default: begin
          rmag = a_mag * b_den; rneg = a_neg != b_neg; rden = a_den * b_mag;
        end
      endcase
      x = rmag; y = rden;
      while (y != 0) begin
        t = x % y; x = y; y = t;
      end
      g = x;
      rmag = rmag / g; rden = rden / g;
      if (rmag == 0) rneg = 0;
      lim = 64'd1 << (rau_pkg::WIDTH - 1);
      if (!(rneg ? (rmag <= lim) : (rmag < lim)) || rden >= lim) r.status = rau_pkg::ST_OVF;
    end
    if (r.status == rau_pkg::ST_ZERO) begin
      r.num = 0; r.den = 0;
    end else begin
      v = rneg ? -rmag : rmag;
      r.num = 32'(signed'(rau_pkg::WIDTH'(v)));
      r.den = 31'(rden & ((64'd1 << (rau_pkg::WIDTH - 1)) - 1));
    end
    return r;
  endfunction

  task automatic send_fraction(input logic [2:0] op, input logic [31:0] an, ad, bn, bd);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {bd, bn, ad, an};
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(compute_fraction(op, an, ad, bn, bd));
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    quotient_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_tdata[31:0] !== e.num) begin
          $error("res_num expected %h got %h", e.num, m_tdata[31:0]); errors++;
        end
        if (m_tdata[62:32] !== e.den) begin
          $error("res_den expected %h got %h", e.den, m_tdata[62:32]); errors++;
        end
        if (m_tuser[0] !== e.less) begin
          $error("a_less expected %b got %b", e.less, m_tuser[0]); errors++;
        end
        if (m_tuser[1] !== e.equal) begin
          $error("a_equal expected %b got %b", e.equal, m_tuser[1]); errors++;
        end
        if (m_tuser[3:2] !== e.status) begin
          $error("status expected %h got %h", e.status, m_tuser[3:2]); errors++;
        end
      end
    end
  end

  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand;
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(20);
      2: return -$urandom_range(20);
      3: return 32'($urandom_range(1000)) - 500;
      4: return {1'($urandom_range(1)), 31'($urandom)} >> $urandom_range(31);
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'd1;
        endcase
      end
    endcase
  endfunction

  task automatic test_directed;
    logic [31:0] corner[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 1, 32'd6};
    send_fraction(rau_pkg::OP_NORM, 32'd6, 32'hffff_fffc, 0, 0);
    send_fraction(rau_pkg::OP_NORM, 32'd5, 0, 1, 1);
    send_fraction(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_fraction(rau_pkg::OP_MUL, 32'hffff_fffd, 32'd4, 32'd8, 32'hffff_fffa);
    send_fraction(rau_pkg::OP_DIV, 32'd3, 32'd4, 0, 32'd5);
    send_fraction(rau_pkg::OP_DIV, 32'd3, 32'd4, 32'd7, 32'hffff_fff7);
    send_fraction(rau_pkg::OP_ADD, 32'd1, 32'd1, 32'd1, 0);
    send_fraction(3'd5, 32'd4, 32'd8, 1, 1);
    send_fraction(3'd6, 32'hffff_fff0, 32'd12, 1, 1);
    send_fraction(3'd7, 32'd9, 32'hffff_fffd, 1, 1);
    send_fraction(rau_pkg::OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    send_fraction(rau_pkg::OP_SUB, 32'h8000_0000, 1, 1, 1);
    send_fraction(rau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff);
    send_fraction(rau_pkg::OP_DIV, 32'h8000_0000, 1, 32'hffff_ffff, 1);
    send_fraction(rau_pkg::OP_NORM, 32'h8000_0000, 32'hffff_ffff, 0, 0);
    for (int i = 0; i < 6; i++)
      send_fraction(3'(i % 5), corner[i], corner[(i + 1) % 6], corner[(i + 2) % 6],
                    corner[(i + 3) % 6]);
    drain();
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    send_idle_pct = idle; recv_stall_pct = stall;
    for (int i = 0; i < count; i++)
      send_fraction(3'($urandom_range(7)), rand_operand(), rand_operand(), rand_operand(),
                    rand_operand());
    drain();
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  task automatic test_backpressure;
    hold_off = 20000;
    for (int i = 0; i < 10; i++)
      send_fraction(3'($urandom_range(4)), rand_operand(), rand_operand(), rand_operand(),
                    rand_operand());
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500, 0, 0);
    test_random(300, 75, 0);
    test_random(300, 0, 75);
    test_random(300, 27, 27);
    test_backpressure();
    test_random(200, 0, 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
